[rtl/cows_pkg.sv]
`timescale 1ns / 1ps
package cows_pkg;
  localparam int SLAB_OBJECTS_DEF    = 64;
  localparam int OVERLAY_ENTRIES_DEF = 16;
  localparam int PAYLOAD_BYTES_DEF   = 48;
  localparam int TEMPLATE_SLOTS_DEF  = 30;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] REG_SLAB     = 2'd0;
  localparam logic [1:0] REG_TEMPLATE = 2'd1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SEALED = 3'd1;
  localparam logic [2:0] ST_REGION = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam logic [7:0] TEMPLATE_BASE = 8'h50;  // 'P'
  localparam logic [4:0] PROMO_MAX = 5'd31;

  // template byte for a 6-bit id: 'P' + ((id mod slots) mod 10)
  // slot and digit counters are walked over all 64 ids, giving a constant mux
  function automatic logic [7:0] template_byte(input logic [5:0] id, input int slots);
    int s;
    int d;
    logic [7:0] b;
    begin
      s = 0;
      d = 0;
      b = TEMPLATE_BASE;
      for (int i = 0; i < 64; i++) begin
        if (id == 6'(i)) b = TEMPLATE_BASE + 8'(d);
        s = s + 1;
        d = d + 1;
        if (d == 10) d = 0;
        if (s == slots) begin
          s = 0;
          d = 0;
        end
      end
      template_byte = b;
    end
  endfunction
endpackage

[rtl/copy_on_write_overlay_store_unit.sv]
`timescale 1ns / 1ps
// Copy-on-write overlay store.
// Command channel: start with command/region/object_id/byte_offset/data_byte,
// taken when start is high and busy is low. One result item per command on
// status/read_byte/from_copy/promo_total, marked by done for one cycle;
// the receiver cannot stall, results are never held.
// slab_sealed_we/slab_sealed_wd write the seal register; the user must
// write it only while idle, which the block itself does not enforce. Load,
// clear and errors go from decode to done; reads pass a read state (overlay
// key scan is a compare against registered keys, payload memory read is
// registered). A write hitting an existing copy goes from decode to patch;
// a promoting write copies PAYLOAD_BYTES bytes through the write port of
// the overlay memory, one byte per cycle after a registered source read.
// One item at a time; busy is high from acceptance to its result. Reset:
// after rst a clearing pass zeroes the slab memory one byte per cycle with
// busy high; overlay valid bits, promotion count and seal clear at once.
module copy_on_write_overlay_store_unit
  import cows_pkg::*;
#(
  parameter int SLAB_OBJECTS    = SLAB_OBJECTS_DEF,
  parameter int OVERLAY_ENTRIES = OVERLAY_ENTRIES_DEF,
  parameter int PAYLOAD_BYTES   = PAYLOAD_BYTES_DEF,
  parameter int TEMPLATE_SLOTS  = TEMPLATE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [1:0] region,
  input  logic [5:0] object_id,
  input  logic [5:0] byte_offset,
  input  logic [7:0] data_byte,
  input  logic       slab_sealed_we,
  input  logic       slab_sealed_wd,
  output logic       done,
  output logic [2:0] status,
  output logic [7:0] read_byte,
  output logic       from_copy,
  output logic [4:0] promo_total
);
  localparam int SLAB_DEPTH = SLAB_OBJECTS * PAYLOAD_BYTES;
  localparam int OVL_DEPTH  = OVERLAY_ENTRIES * PAYLOAD_BYTES;
  localparam int SAW = (SLAB_DEPTH > 1) ? $clog2(SLAB_DEPTH) : 1;
  localparam int OAW = (OVL_DEPTH > 1) ? $clog2(OVL_DEPTH) : 1;
  localparam int EW  = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 1;
  localparam int BW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int BCW = $clog2(PAYLOAD_BYTES + 1);
  localparam int CW  = $clog2(SLAB_DEPTH + 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_PATCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0] slab_mem [SLAB_DEPTH];
  logic [7:0] ovl_mem [OVL_DEPTH];
  logic [6:0] ovl_key [OVERLAY_ENTRIES];
  logic [OVERLAY_ENTRIES-1:0] ovl_valid;

  logic       sealed;
  logic [4:0] promotions;
  logic [CW-1:0] init_cnt;

  logic [1:0] cmd_q, reg_q;
  logic [5:0] id_q, off_q;
  logic [7:0] data_q;

  // slab port
  logic          slab_we;
  logic [SAW-1:0] slab_wa, slab_ra;
  logic [7:0]    slab_wd, slab_rd;
  // overlay port
  logic          ovl_we;
  logic [OAW-1:0] ovl_wa, ovl_ra;
  logic [7:0]    ovl_wd, ovl_rd;

  always_ff @(posedge clk) begin
    if (slab_we) slab_mem[slab_wa] <= slab_wd;
    slab_rd <= slab_mem[slab_ra];
  end
  always_ff @(posedge clk) begin
    if (ovl_we) ovl_mem[ovl_wa] <= ovl_wd;
    ovl_rd <= ovl_mem[ovl_ra];
  end

  // key match and free-entry search over registered keys
  logic [6:0] key_q;
  logic          hit;
  logic [EW-1:0] hit_idx, free_idx;
  logic          have_free;
  assign key_q = {reg_q[0], id_q};
  always_comb begin
    hit = 1'b0; hit_idx = '0; have_free = 1'b0; free_idx = '0;
    for (int i = OVERLAY_ENTRIES - 1; i >= 0; i--) begin
      if (ovl_valid[i] && ovl_key[i] == key_q) begin
        hit = 1'b1; hit_idx = EW'(i);
      end
      if (!ovl_valid[i]) begin
        have_free = 1'b1; free_idx = EW'(i);
      end
    end
  end

  logic [EW-1:0]  ent;
  logic [BCW-1:0] bcnt;   // copy read index
  logic           cp_rd_ok; // a source byte is in the read register
  logic [BW-1:0]  cp_wb;   // byte index of that source byte
  logic [2:0]     st_r;
  logic [7:0]     rb_r;
  logic           fc_r;
  logic           rd_tmpl;

  logic [SAW-1:0] slab_addr_q;
  logic [OAW-1:0] ovl_hit_addr;
  assign slab_addr_q  = SAW'(int'(id_q) * PAYLOAD_BYTES + int'(off_q));
  assign ovl_hit_addr = OAW'(int'(hit_idx) * PAYLOAD_BYTES + int'(off_q));

  logic range_bad;
  assign range_bad = (reg_q == REG_SLAB && int'(id_q) >= SLAB_OBJECTS) ||
                     int'(off_q) >= PAYLOAD_BYTES;

  always_comb begin
    slab_we = 1'b0; slab_wa = slab_addr_q; slab_wd = data_q;
    slab_ra = SAW'(int'(id_q) * PAYLOAD_BYTES + int'(bcnt));
    ovl_we = 1'b0; ovl_wa = '0; ovl_wd = data_q; ovl_ra = ovl_hit_addr;
    if (state == S_INIT) begin
      slab_we = 1'b1; slab_wa = init_cnt[SAW-1:0]; slab_wd = '0;
    end else if (state == S_DEC) begin
      if (cmd_q == CMD_LOAD && !sealed && reg_q == REG_SLAB && !range_bad)
        slab_we = 1'b1;
      if (cmd_q == CMD_READ) slab_ra = slab_addr_q;
    end else if (state == S_COPY && cp_rd_ok) begin
      ovl_we = 1'b1;
      ovl_wa = OAW'(int'(ent) * PAYLOAD_BYTES + int'(cp_wb));
      ovl_wd = (reg_q == REG_SLAB) ? slab_rd : template_byte(id_q, TEMPLATE_SLOTS);
    end else if (state == S_PATCH) begin
      ovl_we = 1'b1;
      ovl_wa = OAW'(int'(ent) * PAYLOAD_BYTES + int'(off_q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_cnt <= '0; ovl_valid <= '0;
      promotions <= '0; sealed <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (slab_sealed_we) sealed <= slab_sealed_wd;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (int'(init_cnt) == SLAB_DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= command; reg_q <= region; id_q <= object_id;
            off_q <= byte_offset; data_q <= data_byte;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          st_r <= ST_OK; rb_r <= '0; fc_r <= 1'b0;
          state <= S_DONE;
          if (cmd_q == CMD_LOAD) begin
            if (sealed) st_r <= ST_SEALED;
            else if (reg_q != REG_SLAB) st_r <= ST_REGION;
            else if (range_bad) st_r <= ST_RANGE;
          end else if (cmd_q == CMD_CLEAR) begin
            ovl_valid <= '0; promotions <= '0;
          end else if (reg_q[1]) begin
            st_r <= ST_REGION;
          end else if (range_bad) begin
            st_r <= ST_RANGE;
          end else if (cmd_q == CMD_READ) begin
            fc_r <= hit; rd_tmpl <= (reg_q == REG_TEMPLATE);
            state <= S_RD;
          end else if (hit) begin
            ent <= hit_idx; state <= S_PATCH;
          end else if (!have_free) begin
            st_r <= ST_FULL;
          end else begin
            ent <= free_idx; bcnt <= '0; cp_rd_ok <= 1'b0;
            ovl_key[free_idx] <= key_q;
            state <= S_COPY;
          end
        end
        S_RD: begin
          if (fc_r) rb_r <= ovl_rd;
          else if (rd_tmpl) rb_r <= template_byte(id_q, TEMPLATE_SLOTS);
          else rb_r <= slab_rd;
          state <= S_DONE;
        end
        S_COPY: begin
          // slab read for bcnt issued this cycle, written next cycle
          cp_wb <= BW'(bcnt);
          if (int'(bcnt) < PAYLOAD_BYTES) begin
            cp_rd_ok <= 1'b1; bcnt <= bcnt + 1'b1;
          end else begin
            cp_rd_ok <= 1'b0;
            ovl_valid[ent] <= 1'b1;
            if (promotions != PROMO_MAX) promotions <= promotions + 1'b1;
            state <= S_PATCH;
          end
        end
        S_PATCH: state <= S_DONE;
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign status = st_r;
  assign read_byte = rb_r;
  assign from_copy = fc_r;
  assign promo_total = promotions;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held two cycles");
  a_fc_ok: assert property (@(posedge clk) disable iff (rst)
    done && from_copy |-> status == ST_OK)
    else $error("copy flag on failed item");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> read_byte == '0)
    else $error("read byte on failed item");
  a_promo_max: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> have_free || ovl_valid[ent] == 1'b0)
    else $error("copy into valid entry");
endmodule

[bench/copy_on_write_overlay_store_unit_tb.sv]
`timescale 1ns / 1ps
module copy_on_write_overlay_store_unit_tb;
  import cows_pkg::*;

  localparam int SLAB_OBJ = 64;
  localparam int OV_ENTRIES = 16;
  localparam int PAY_BYTES = 48;
  localparam int TPL_SLOTS = 30;

  typedef struct {
    bit         is_seal;
    bit         seal_val;
    bit         no_gap;
    logic [1:0] cmd;
    logic [1:0] rgn;
    logic [5:0] id;
    logic [5:0] off;
    logic [7:0] data;
  } req_t;

  typedef struct {
    logic [2:0] st;
    logic [7:0] rbyte;
    logic       fc;
    logic [4:0] promos;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] command = '0;
  logic [1:0] region = '0;
  logic [5:0] object_id = '0;
  logic [5:0] byte_offset = '0;
  logic [7:0] data_byte = '0;
  logic       slab_sealed_we = 1'b0;
  logic       slab_sealed_wd = 1'b0;
  logic       done;
  logic [2:0] status;
  logic [7:0] read_byte;
  logic       from_copy;
  logic [4:0] promo_total;

  copy_on_write_overlay_store_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .region(region), .object_id(object_id),
    .byte_offset(byte_offset), .data_byte(data_byte),
    .slab_sealed_we(slab_sealed_we), .slab_sealed_wd(slab_sealed_wd),
    .done(done), .status(status), .read_byte(read_byte),
    .from_copy(from_copy), .promo_total(promo_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the store
  logic [7:0] slab_mem [SLAB_OBJ*PAY_BYTES];
  bit         copy_valid [OV_ENTRIES];
  logic [6:0] copy_key [OV_ENTRIES];
  logic [7:0] copy_mem [OV_ENTRIES*PAY_BYTES];
  logic [4:0] promo_cnt;
  bit         sealed;

  req_t    pending[$];
  answer_t answers[$];
  req_t    cur;
  int      gap;
  int      errors = 0;

  function automatic logic [7:0] source_byte(logic [1:0] rgn, logic [5:0] id, int off);
    if (rgn == REG_SLAB) return slab_mem[int'(id)*PAY_BYTES + off];
    return 8'h50 + 8'((int'(id) % TPL_SLOTS) % 10);
  endfunction

  function automatic int find_copy(logic [6:0] key);
    for (int i = 0; i < OV_ENTRIES; i++)
      if (copy_valid[i] && copy_key[i] == key) return i;
    return -1;
  endfunction

  function automatic answer_t apply_command(req_t r);
    answer_t a;
    logic [6:0] key;
    int e;
    a = '{ST_OK, 8'd0, 1'b0, 5'd0};
    key = {r.rgn[0], r.id};
    if (r.cmd == CMD_LOAD) begin
      if (sealed) a.st = ST_SEALED;
      else if (r.rgn != REG_SLAB) a.st = ST_REGION;
      else if (r.id >= SLAB_OBJ || r.off >= PAY_BYTES) a.st = ST_RANGE;
      else slab_mem[int'(r.id)*PAY_BYTES + int'(r.off)] = r.data;
    end else if (r.cmd == CMD_CLEAR) begin
      for (int i = 0; i < OV_ENTRIES; i++) copy_valid[i] = 1'b0;
      promo_cnt = '0;
    end else if (r.rgn > REG_TEMPLATE) begin
      a.st = ST_REGION;
    end else if ((r.rgn == REG_SLAB && r.id >= SLAB_OBJ) || r.off >= PAY_BYTES) begin
      a.st = ST_RANGE;
    end else if (r.cmd == CMD_READ) begin
      e = find_copy(key);
      if (e >= 0) begin
        a.rbyte = copy_mem[e*PAY_BYTES + int'(r.off)];
        a.fc = 1'b1;
      end else begin
        a.rbyte = source_byte(r.rgn, r.id, int'(r.off));
      end
    end else begin
      e = find_copy(key);
      if (e < 0) begin
        for (int i = 0; i < OV_ENTRIES; i++)
          if (!copy_valid[i]) begin
            e = i;
            break;
          end
        if (e < 0) a.st = ST_FULL;
        else begin
          for (int b = 0; b < PAY_BYTES; b++)
            copy_mem[e*PAY_BYTES + b] = source_byte(r.rgn, r.id, b);
          copy_valid[e] = 1'b1;
          copy_key[e] = key;
          if (promo_cnt != PROMO_MAX) promo_cnt = promo_cnt + 5'd1;
        end
      end
      if (e >= 0) copy_mem[e*PAY_BYTES + int'(r.off)] = r.data;
    end
    a.promos = promo_cnt;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    bit   acc, n_start, n_we, n_load;
    int   n_gap;
    req_t nxt;
    n_load = 1'b0;
    n_we = 1'b0;
    if (rst) begin
      start <= 1'b0;
      slab_sealed_we <= 1'b0;
      gap <= 0;
    end else begin
      acc = start && !busy;
      n_start = start && !acc;
      n_gap = gap;
      if (acc) answers.insert(answers.size(), apply_command(cur));
      if (!n_start) begin
        if (gap > 0) n_gap = gap - 1;
        else if (pending.size() > 0) begin
          if (pending[0].is_seal) begin
            // register writes only with nothing in flight
            if (!acc && !busy && !done && answers.size() == 0) begin
              nxt = pending.pop_front();
              sealed = nxt.seal_val;
              n_we = 1'b1;
              slab_sealed_wd <= nxt.seal_val;
            end
          end else if (!pending[0].no_gap && $urandom_range(0, 6) == 0) begin
            n_gap = $urandom_range(1, 8);
          end else begin
            nxt = pending.pop_front();
            n_start = 1'b1;
            n_load = 1'b1;
          end
        end
      end
      start <= n_start;
      slab_sealed_we <= n_we;
      gap <= n_gap;
      if (n_load) begin
        cur <= nxt;
        command <= nxt.cmd;
        region <= nxt.rgn;
        object_id <= nxt.id;
        byte_offset <= nxt.off;
        data_byte <= nxt.data;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (answers.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        w = answers.pop_front();
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (read_byte !== w.rbyte) report_mismatch("read_byte", read_byte, w.rbyte);
        if (from_copy !== w.fc) report_mismatch("from_copy", from_copy, w.fc);
        if (promo_total !== w.promos)
          report_mismatch("promo_total", promo_total, w.promos);
      end
    end
  end

  task automatic add_cmd(logic [1:0] c, logic [1:0] r, logic [5:0] id, logic [5:0] off,
                         logic [7:0] d, bit ng = 1'b0);
    req_t q;
    q = '{1'b0, 1'b0, ng, c, r, id, off, d};
    pending.insert(pending.size(), q);
  endtask

  task automatic add_seal(bit v);
    req_t q;
    q = '{1'b1, v, 1'b0, CMD_READ, REG_SLAB, 6'd0, 6'd0, 8'd0};
    pending.insert(pending.size(), q);
  endtask

  task automatic add_random(int n, bit ng);
    int k;
    logic [1:0] c, r;
    logic [5:0] id, off;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      c = k < 22 ? CMD_LOAD : k < 58 ? CMD_READ : k < 97 ? CMD_WRITE : CMD_CLEAR;
      r = $urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      id = $urandom_range(0, 9) < 3 ? 6'($urandom) : 6'($urandom_range(0, 19));
      off = $urandom_range(0, 9) == 0 ? 6'($urandom_range(48, 63)) : 6'($urandom_range(0, 47));
      add_cmd(c, r, id, off, 8'($urandom), ng);
    end
  endtask

  initial begin
    for (int i = 0; i < SLAB_OBJ*PAY_BYTES; i++) slab_mem[i] = '0;
    for (int i = 0; i < OV_ENTRIES; i++) copy_valid[i] = 1'b0;
    promo_cnt = '0;
    sealed = 1'b0;

    // directed: field extremes, every command, wrap and aliasing, seal, errors
    add_cmd(CMD_LOAD, REG_SLAB, 6'd0, 6'd0, 8'hFF);
    add_cmd(CMD_LOAD, REG_SLAB, 6'd63, 6'd47, 8'h00);
    add_cmd(CMD_LOAD, REG_SLAB, 6'd63, 6'd46, 8'hA5);
    add_cmd(CMD_LOAD, REG_TEMPLATE, 6'd1, 6'd1, 8'h11);
    add_cmd(CMD_LOAD, 2'd3, 6'd1, 6'd1, 8'h11);
    add_cmd(CMD_LOAD, REG_SLAB, 6'd5, 6'd48, 8'h22);
    add_cmd(CMD_LOAD, REG_SLAB, 6'd5, 6'd63, 8'h22);
    add_cmd(CMD_READ, REG_SLAB, 6'd63, 6'd46, 8'hFF);
    add_cmd(CMD_READ, REG_SLAB, 6'd0, 6'd0, 8'h00);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd0, 6'd0, 8'h00);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd29, 6'd47, 8'h00);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd63, 6'd3, 8'h00);
    add_cmd(CMD_READ, 2'd2, 6'd0, 6'd0, 8'h00);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd0, 6'd48, 8'h00);
    add_cmd(CMD_WRITE, 2'd3, 6'd0, 6'd0, 8'h33);
    add_cmd(CMD_WRITE, REG_TEMPLATE, 6'd5, 6'd7, 8'h77);
    add_cmd(CMD_WRITE, REG_TEMPLATE, 6'd35, 6'd7, 8'h88);   // same slot, own copy
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd5, 6'd7, 8'h00);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd35, 6'd8, 8'h00);
    add_cmd(CMD_WRITE, REG_SLAB, 6'd63, 6'd0, 8'h5A);
    add_cmd(CMD_READ, REG_SLAB, 6'd63, 6'd46, 8'h00);
    add_cmd(CMD_CLEAR, 2'd3, 6'd63, 6'd63, 8'hFF);
    add_cmd(CMD_READ, REG_TEMPLATE, 6'd5, 6'd7, 8'h00);
    add_seal(1'b1);
    add_cmd(CMD_LOAD, REG_SLAB, 6'd1, 6'd1, 8'h44);
    add_cmd(CMD_LOAD, 2'd2, 6'd1, 6'd60, 8'h44);             // seal checked first
    add_seal(1'b0);

    // overlay full: 17 distinct writes, the last finds all 16 entries taken
    for (int i = 0; i < 17; i++) add_cmd(CMD_WRITE, REG_SLAB, 6'(i), 6'(i), 8'(i * 13));
    add_cmd(CMD_CLEAR, REG_SLAB, 6'd0, 6'd0, 8'd0);

    add_random(200, 1'b0);
    add_seal(1'b1);
    add_random(200, 1'b0);
    add_seal(1'b0);
    add_random(150, 1'b0);
    add_seal(1'b1);
    add_random(30, 1'b0);
    add_seal(1'b0);
    add_random(100, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending.size() != 0 || start || answers.size() != 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("copy_on_write_overlay_store_unit regression: pass");
    else $display("copy_on_write_overlay_store_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("copy_on_write_overlay_store_unit regression: fail");
    $finish;
  end

endmodule
